### hdl/lpd_pkg.sv
// lpd_pkg: shared types and constants for the length prefix deframer
// no dependencies
`timescale 1ns / 1ps

package lpd_pkg;

   localparam int unsigned HEADER_LEN   = 4;
   localparam int unsigned HEADER_BITS  = 24;
   localparam int unsigned LEN_W        = 32;
   localparam int unsigned RUN_W        = 8;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam logic [LEN_W-1:0] RESET_MAX_FRAME_LEN = LEN_W'(10 * 1024 * 1024);
   localparam logic [RUN_W-1:0] RESET_MAX_EMPTY_RUN = RUN_W'(10);

   // result status codes
   localparam logic [STATUS_W-1:0] ST_PAYLOAD         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CLOSED_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CLOSED_OVERSIZE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_LEN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_EMPTY_RUN = 2'd1;

   typedef struct packed {
      logic [BYTE_W-1:0]   payload_byte;
      logic                frame_first;
      logic                frame_last;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_push_type;

   typedef struct packed {
      logic closed;
      logic in_payload;
   } core_status_type;

endpackage

### hdl/lpd_core.sv
// lpd_core: header collection, payload pass-through and close detection
// depends on lpd_pkg
`timescale 1ns / 1ps

module lpd_core
   import lpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [BYTE_W-1:0]    rx_byte,
   input  logic [LEN_W-1:0]     max_frame_len,
   input  logic [RUN_W-1:0]     max_empty_run,
   output rsp_push_type         push,
   output core_status_type      core_status
);

   logic [1:0]             header_count_ff, header_count_in;
   logic [HEADER_BITS-1:0] header_bytes_ff, header_bytes_in;
   logic [LEN_W-1:0]       payload_left_ff, payload_left_in;
   logic                   payload_started_ff, payload_started_in;
   logic [RUN_W-1:0]       empty_run_ff, empty_run_in;
   logic                   closed_ff, closed_in;
   logic [LEN_W-1:0]       frame_len;
   logic [LEN_W-1:0]       left_dec;

   assign frame_len = {header_bytes_ff, rx_byte};
   assign left_dec  = payload_left_ff - LEN_W'(1);

   always_comb begin
      header_count_in    = header_count_ff;
      header_bytes_in    = header_bytes_ff;
      payload_left_in    = payload_left_ff;
      payload_started_in = payload_started_ff;
      empty_run_in       = empty_run_ff;
      closed_in          = closed_ff;
      push               = '0;
      if (accept && !closed_ff) begin
         if (payload_left_ff != '0) begin
            // payload byte
            push.valid             = 1'b1;
            push.data.payload_byte = rx_byte;
            push.data.frame_first  = !payload_started_ff;
            push.data.frame_last   = (payload_left_ff == LEN_W'(1));
            push.data.status       = ST_PAYLOAD;
            payload_left_in        = left_dec;
            payload_started_in     = (left_dec != '0);
         end else if (header_count_ff != 2'(HEADER_LEN - 1)) begin
            header_bytes_in = {header_bytes_ff[HEADER_BITS-BYTE_W-1:0], rx_byte};
            header_count_in = header_count_ff + 2'd1;
         end else begin
            header_count_in = '0;
            header_bytes_in = '0;
            if (frame_len == '0) begin
               if (empty_run_ff >= max_empty_run) begin
                  closed_in        = 1'b1;
                  push.valid       = 1'b1;
                  push.data.status = ST_CLOSED_EMPTY;
               end else begin
                  empty_run_in = empty_run_ff + RUN_W'(1);
               end
            end else begin
               empty_run_in = '0;
               if (frame_len > max_frame_len) begin
                  closed_in        = 1'b1;
                  push.valid       = 1'b1;
                  push.data.status = ST_CLOSED_OVERSIZE;
               end else begin
                  payload_left_in    = frame_len;
                  payload_started_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff    <= '0;
         header_bytes_ff    <= '0;
         payload_left_ff    <= '0;
         payload_started_ff <= 1'b0;
         empty_run_ff       <= '0;
         closed_ff          <= 1'b0;
      end else begin
         header_count_ff    <= header_count_in;
         header_bytes_ff    <= header_bytes_in;
         payload_left_ff    <= payload_left_in;
         payload_started_ff <= payload_started_in;
         empty_run_ff       <= empty_run_in;
         closed_ff          <= closed_in;
      end
   end

   assign core_status.closed     = closed_ff;
   assign core_status.in_payload = (payload_left_ff != '0);

endmodule

### hdl/lpd_out_buf.sv
// lpd_out_buf: two-entry result buffer decoupling the request side from rsp_stall
// depends on lpd_pkg
`timescale 1ns / 1ps

module lpd_out_buf
   import lpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;
   logic [1:0] wr_pos;

   assign pop    = (count_ff != 2'd0) && !rsp_stall;
   assign wr_pos = count_ff - {1'b0, pop};

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push.valid) begin
         if (wr_pos == 2'd0) begin
            slot0_in = push.data;
         end else begin
            slot1_in = push.data;
         end
      end
      count_in = count_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

endmodule

### hdl/length_prefix_deframer.sv
// length_prefix_deframer: top level, configuration registers, core and result buffer
// depends on lpd_pkg, lpd_core, lpd_out_buf
// a result is registered in the result buffer and reaches rsp_* behind any results still waiting
// throughput: one request per cycle while req_stall is low; req_stall rises only when two results wait
// reset: synchronous, clears frame state, close flag and the result buffer,
// and loads max_frame_len = 10485760 and max_empty_run = 10
`timescale 1ns / 1ps

module length_prefix_deframer
   import lpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BYTE_W-1:0]      rsp_payload_byte,
   output logic                   rsp_frame_first,
   output logic                   rsp_frame_last,
   output logic [STATUS_W-1:0]    rsp_status,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [LEN_W-1:0] max_frame_len_ff;
   logic [RUN_W-1:0] max_empty_run_ff;
   logic             req_accept;
   logic             buf_full;
   rsp_push_type     push;
   rsp_type          rsp_data;
   core_status_type  core_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff <= RESET_MAX_FRAME_LEN;
         max_empty_run_ff <= RESET_MAX_EMPTY_RUN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_FRAME_LEN: max_frame_len_ff <= csr_data[LEN_W-1:0];
            CSR_MAX_EMPTY_RUN: max_empty_run_ff <= csr_data[RUN_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   lpd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .rx_byte       (req_rx_byte),
      .max_frame_len (max_frame_len_ff),
      .max_empty_run (max_empty_run_ff),
      .push          (push),
      .core_status   (core_status)
   );

   lpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_frame_first  = rsp_data.frame_first;
   assign rsp_frame_last   = rsp_data.frame_last;
   assign rsp_status       = rsp_data.status;

   // a close report is followed by the closed state
   a_close_sets_closed: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.data.status != ST_PAYLOAD) |=> core_status.closed)
      else $error("close report without closed state");

   // nothing is produced once closed
   a_no_result_after_close: assert property (@(posedge clock) disable iff (reset)
      core_status.closed |-> !push.valid)
      else $error("result produced after close");

   // a stall on the request side only while results are waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   // payload results only come while a frame is in progress
   a_payload_in_frame: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.data.status == ST_PAYLOAD) |-> core_status.in_payload)
      else $error("payload byte outside a frame");

endmodule

### dv/tb.sv
// tb: self-checking testbench for length_prefix_deframer, a directed table, random frames, then a stream close
// a behavioural deframer predicts the responses the directed table does not give; depends on lpd_pkg and the rtl only
`timescale 1ns / 1ps

module tb;
   import lpd_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 2'd3;

   typedef enum int {CLOSE_EMPTY_RUN, CLOSE_OVERSIZE, CLOSE_ZERO_LIMIT} close_kind_type;

   typedef struct {
      logic [BYTE_W-1:0] rx_byte;
      bit                typed;
      bit                has_rsp;
      rsp_type           rsp;
      bit                shrink_before;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BYTE_W-1:0]      rsp_payload_byte;
   logic                   rsp_frame_first;
   logic                   rsp_frame_last;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   length_prefix_deframer dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register mirror
   logic [LEN_W-1:0] max_len = RESET_MAX_FRAME_LEN;
   logic [RUN_W-1:0] max_empties = RESET_MAX_EMPTY_RUN;

   // deframer state mirror
   logic [1:0]             hdr_count = '0;
   logic [HEADER_BITS-1:0] hdr_acc = '0;
   logic [LEN_W-1:0]       bytes_left = '0;
   logic                   mid_frame = 1'b0;
   logic [RUN_W-1:0]       empty_count = '0;
   logic                   closed_flag = 1'b0;

   rsp_type        expected_rsps[$];
   stim_row_type   directed_rows[$];
   rsp_type        want;
   int             err_count = 0;
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;
   int             hold_requests = 0;
   int             hold_seen = 0;
   int             hold_left = 0;
   int             gen_empties = 0;

   function automatic void deframe_byte(input logic [BYTE_W-1:0] b, output bit got,
                                        output rsp_type r);
      logic [LEN_W-1:0] len;
      got = 1'b0;
      r = '0;
      if (closed_flag) return;
      if (bytes_left != 0) begin
         got = 1'b1;
         r.payload_byte = b;
         r.frame_first = !mid_frame;
         r.frame_last = (bytes_left == 1);
         r.status = ST_PAYLOAD;
         bytes_left = bytes_left - 1;
         mid_frame = (bytes_left != 0);
      end else if (hdr_count < HEADER_LEN - 1) begin
         hdr_acc = {hdr_acc[HEADER_BITS-9:0], b};
         hdr_count = hdr_count + 2'd1;
      end else begin
         len = {hdr_acc, b};
         hdr_count = '0;
         hdr_acc = '0;
         if (len == 0) begin
            if (empty_count >= max_empties) begin
               got = 1'b1;
               r.status = ST_CLOSED_EMPTY;
               closed_flag = 1'b1;
            end else begin
               empty_count = empty_count + RUN_W'(1);
            end
         end else begin
            empty_count = '0;
            if (len > max_len) begin
               got = 1'b1;
               r.status = ST_CLOSED_OVERSIZE;
               closed_flag = 1'b1;
            end else begin
               bytes_left = len;
               mid_frame = 1'b0;
            end
         end
      end
   endfunction

   function automatic rsp_type payload_rsp(logic [BYTE_W-1:0] b, logic first, logic last);
      payload_rsp = '{payload_byte: b, frame_first: first, frame_last: last, status: ST_PAYLOAD};
   endfunction

   function automatic void add_row(logic [BYTE_W-1:0] b, bit typed = 1'b0, bit has_rsp = 1'b0,
                                   rsp_type rsp = '0, bit shrink_before = 1'b0);
      directed_rows.push_back('{b, typed, has_rsp, rsp, shrink_before});
   endfunction

   task automatic send_byte(logic [BYTE_W-1:0] b, bit typed = 1'b0, bit t_has = 1'b0,
                            rsp_type t_rsp = '0);
      bit      got;
      rsp_type pred;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      deframe_byte(b, got, pred);
      if (typed) begin
         got = t_has;
         pred = t_rsp;
      end
      if (got) expected_rsps.push_back(pred);
   endtask

   task automatic send_header(logic [LEN_W-1:0] len);
      send_byte(len[31:24]);
      send_byte(len[23:16]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      gen_empties = (len == 0) ? gen_empties + 1 : 0;
   endtask

   task automatic send_frame(logic [LEN_W-1:0] len);
      send_header(len);
      repeat (len) send_byte(BYTE_W'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      if (idx == CSR_MAX_FRAME_LEN) max_len = data;
      else if (idx == CSR_MAX_EMPTY_RUN) max_empties = data[RUN_W-1:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_frames(int target);
      int          sent;
      int unsigned lim;
      int unsigned pick;
      int unsigned len;
      sent = 0;
      while (sent < target) begin
         lim = (max_len < 64) ? max_len : 64;
         pick = $urandom_range(9);
         if (pick == 0 && gen_empties < max_empties) len = 0;
         else if (pick == 1 && max_len >= 300) len = $urandom_range(256, 300);
         else if (pick == 2) len = lim;
         else len = $urandom_range(1, (lim < 12) ? lim : 12);
         send_frame(len);
         sent += HEADER_LEN + len;
      end
   endtask

   // response checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: byte %0h status %0d", rsp_payload_byte, rsp_status);
            err_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload_byte !== want.payload_byte) begin
               $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                      rsp_payload_byte);
               err_count++;
            end
            if (rsp_frame_first !== want.frame_first) begin
               $error("frame_first: expected %0b, got %0b", want.frame_first, rsp_frame_first);
               err_count++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last: expected %0b, got %0b", want.frame_last, rsp_frame_last);
               err_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               err_count++;
            end
         end
      end
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin
      #(100_000 * 12);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      close_kind_type close_kind;
      logic [LEN_W-1:0] len;
      int               n;

      // single-byte frame, empty frame, then a limit change part way through a frame
      repeat (3) add_row(8'h00, 1'b1);
      add_row(8'h01, 1'b1);
      add_row(8'hFF, 1'b1, 1'b1, payload_rsp(8'hFF, 1'b1, 1'b1));
      repeat (4) add_row(8'h00, 1'b1);
      repeat (3) add_row(8'h00, 1'b1);
      add_row(8'h03, 1'b1);
      add_row(8'h00, 1'b1, 1'b1, payload_rsp(8'h00, 1'b1, 1'b0));
      add_row(8'h80, 1'b0, 1'b0, '0, 1'b1);
      add_row(8'h7F);
      repeat (3) add_row(8'h00);
      add_row(8'h01);
      add_row(8'h55);

      req_idle_pct = 22;
      rsp_idle_pct = 46;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].shrink_before) begin
            wait_idle();
            write_csr(CSR_MAX_FRAME_LEN, 1);
         end
         send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                   directed_rows[i].has_rsp, directed_rows[i].rsp);
      end
      gen_empties = 0;

      // widest limits
      wait_idle();
      write_csr(CSR_MAX_FRAME_LEN, 32'hFFFF_FFFF);
      write_csr(CSR_MAX_EMPTY_RUN, 255);
      run_frames(230);

      // small limits, no empty frames allowed
      wait_idle();
      req_idle_pct = 46;
      rsp_idle_pct = 22;
      write_csr(CSR_MAX_FRAME_LEN, $urandom_range(1, 40));
      write_csr(CSR_MAX_EMPTY_RUN, 0);
      write_csr(CSR_INDEX_SPARE, $urandom);
      run_frames(230);

      // no idling, long receiver hold-off first
      wait_idle();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_csr(CSR_MAX_FRAME_LEN, $urandom_range(41, 64));
      write_csr(CSR_MAX_EMPTY_RUN, $urandom_range(1, 12));
      hold_requests++;
      send_frame(40);
      run_frames(200);

      // close the stream, then bytes that are dropped
      wait_idle();
      close_kind = close_kind_type'($urandom_range(2));
      case (close_kind)
         CLOSE_EMPTY_RUN: begin
            write_csr(CSR_MAX_EMPTY_RUN, $urandom_range(3));
            n = (gen_empties >= max_empties) ? 1 : max_empties - gen_empties + 1;
            repeat (n) send_header(0);
         end
         CLOSE_OVERSIZE: begin
            write_csr(CSR_MAX_FRAME_LEN, $urandom_range(1, 1000));
            len = $urandom;
            if (len <= max_len) len = max_len + 1;
            send_header(len);
         end
         default: begin
            write_csr(CSR_MAX_FRAME_LEN, 0);
            len = $urandom;
            if (len == 0) len = 1;
            send_header(len);
         end
      endcase
      repeat (8) send_byte(BYTE_W'($urandom));

      wait_idle();
      repeat (5) @(posedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
hdl/lpd_pkg.sv
hdl/lpd_core.sv
hdl/lpd_out_buf.sv
hdl/length_prefix_deframer.sv
dv/tb.sv
